>>> hw/rtl/keyboard_scancode_assembler_core_assert.svh
`ifndef KEYBOARD_SCANCODE_ASSEMBLER_CORE_ASSERT_SVH
`define KEYBOARD_SCANCODE_ASSEMBLER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define KSA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("keyboard scancode assembler: assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define KSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("keyboard scancode assembler: assertion failed");

`endif

>>> hw/rtl/ksa_pkg.sv
package ksa_pkg;

  localparam logic [7:0]  BYTE_ACK     = 8'hFA;
  localparam logic [7:0]  BYTE_EXT0    = 8'hE0;
  localparam logic [7:0]  BYTE_EXT1    = 8'hE1;
  localparam logic [15:0] EXT_PREFIX   = 16'hE000;
  localparam logic [7:0]  PRINT_PART_A = 8'h2A;
  localparam logic [7:0]  PRINT_PART_B = 8'hB7;

  localparam int PRINT_LEN = 4;
  localparam int PAUSE_LEN = 6;

  localparam logic [7:0] PAT_PRINT_PRESS [PRINT_LEN] = '{8'hE0, 8'h2A, 8'hE0, 8'h37};
  localparam logic [7:0] PAT_PRINT_RELEASE [PRINT_LEN] = '{8'hE0, 8'hB7, 8'hE0, 8'hAA};
  localparam logic [7:0] PAT_PAUSE [PAUSE_LEN] =
    '{8'hE1, 8'h1D, 8'h45, 8'hE1, 8'h9D, 8'hC5};

  typedef enum logic [2:0] {
    KIND_SINGLE        = 3'd0,
    KIND_EXTENDED      = 3'd1,
    KIND_PRINT_PRESS   = 3'd2,
    KIND_PRINT_RELEASE = 3'd3,
    KIND_PAUSE         = 3'd4
  } kind_e;

  typedef struct packed {
    logic        ack;
    logic        emit;
    kind_e       kind;
    logic [15:0] code;
  } dec_t;

endpackage

>>> hw/rtl/keyboard_scancode_assembler_core.sv
// Scan-code set 1 sequence assembler.
// Input channel: one keyboard byte per item on scan_byte_i, with in_valid_i
// and in_stall_o. Output channel: one decoded code per item on code_kind_o and
// key_code_o, with out_valid_o and out_stall_i.
// Acknowledge bytes and bytes inside an unfinished sequence give no output item.
// One-byte and E0 extended codes, print-screen press and release, and pause
// each give one output item when their last byte is taken.
// Throughput: one byte per cycle while out_stall_i holds no result. An accepted
// byte sits in the input register, with the sequence match between it and the
// result register; out_valid_o rises when the result register is loaded.
// Reset clears the position counter and both valid flags; the sequence
// buffer holds whatever it had until new bytes are written.
// While out_stall_i holds a result, the input register fills and then
// in_stall_o rises in the same cycle; no byte is lost or repeated.
`include "keyboard_scancode_assembler_core_assert.svh"

module keyboard_scancode_assembler_core
  import ksa_pkg::*;
#(
  parameter int SEQUENCE_DEPTH = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  scan_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  code_kind_o,
  output logic [15:0] key_code_o
);

  localparam int PosW = $clog2(SEQUENCE_DEPTH);

  logic            in_valid_q, in_valid_d;
  logic [7:0]      byte_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      seq_bytes_q [SEQUENCE_DEPTH];
  logic            out_valid_q, out_valid_d;
  kind_e           kind_q;
  logic [15:0]     code_q;

  logic            out_ready;
  logic            advance;
  logic            accept;
  dec_t            dec;
  logic [PosW-1:0] next_pos;

  ksa_decode #(
    .SEQUENCE_DEPTH(SEQUENCE_DEPTH),
    .PosW          (PosW)
  ) u_decode (
    .scan_byte_i(byte_q),
    .pos_i      (pos_q),
    .seq_bytes_i(seq_bytes_q),
    .dec_o      (dec),
    .next_pos_o (next_pos)
  );

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign accept     = in_valid_i && !in_stall_o;

  assign in_valid_d  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign pos_d       = (advance && !dec.ack) ? next_pos : pos_q;
  assign out_valid_d = (advance && dec.emit) ? 1'b1 : (out_ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= scan_byte_i;
    end
    if (advance && !dec.ack) begin
      seq_bytes_q[pos_q] <= byte_q;
    end
    if (advance && dec.emit) begin
      kind_q <= dec.kind;
      code_q <= dec.code;
    end
  end

  assign out_valid_o = out_valid_q;
  assign code_kind_o = kind_q;
  assign key_code_o  = code_q;

  `KSA_ASSERT_NOW(pos_in_range, 1'b1, int'(pos_q) < SEQUENCE_DEPTH)
  `KSA_ASSERT_NEXT(emit_clears_pos, advance && dec.emit, pos_q == '0)
  `KSA_ASSERT_NEXT(ack_holds_pos, advance && dec.ack, $stable(pos_q))
  `KSA_ASSERT_NOW(single_upper_zero, out_valid_q && kind_q == KIND_SINGLE,
                  code_q[15:8] == 8'h00)

endmodule

>>> hw/rtl/ksa_decode.sv
module ksa_decode
  import ksa_pkg::*;
#(
  parameter int SEQUENCE_DEPTH = 6,
  parameter int PosW           = 3
) (
  input  logic [7:0]      scan_byte_i,
  input  logic [PosW-1:0] pos_i,
  input  logic [7:0]      seq_bytes_i [SEQUENCE_DEPTH],
  output dec_t            dec_o,
  output logic [PosW-1:0] next_pos_o
);

  logic [7:0] eff [SEQUENCE_DEPTH];
  logic       press_hit;
  logic       release_hit;
  logic       pause_hit;

  always_comb begin
    for (int i = 0; i < SEQUENCE_DEPTH; i++) begin
      eff[i] = (pos_i == PosW'(i)) ? scan_byte_i : seq_bytes_i[i];
    end
  end

  always_comb begin
    press_hit   = (pos_i >= PosW'(PRINT_LEN - 1));
    release_hit = (pos_i >= PosW'(PRINT_LEN - 1));
    pause_hit   = (pos_i >= PosW'(PAUSE_LEN - 1));
    for (int i = 0; i < PRINT_LEN; i++) begin
      if (eff[i] != PAT_PRINT_PRESS[i]) press_hit = 1'b0;
      if (eff[i] != PAT_PRINT_RELEASE[i]) release_hit = 1'b0;
    end
    for (int i = 0; i < PAUSE_LEN; i++) begin
      if (eff[i] != PAT_PAUSE[i]) pause_hit = 1'b0;
    end
  end

  always_comb begin
    dec_o.ack  = (scan_byte_i == BYTE_ACK);
    dec_o.emit = 1'b0;
    dec_o.kind = KIND_SINGLE;
    dec_o.code = '0;
    priority if (pos_i == '0 && scan_byte_i != BYTE_EXT0 && scan_byte_i != BYTE_EXT1) begin
      dec_o.emit = 1'b1;
      dec_o.code = {8'h00, scan_byte_i};
    end else if (pos_i == PosW'(1) && eff[0] == BYTE_EXT0) begin
      if (scan_byte_i != PRINT_PART_A && scan_byte_i != PRINT_PART_B) begin
        dec_o.emit = 1'b1;
        dec_o.kind = KIND_EXTENDED;
        dec_o.code = EXT_PREFIX | {8'h00, scan_byte_i};
      end
    end else if (press_hit) begin
      dec_o.emit = 1'b1;
      dec_o.kind = KIND_PRINT_PRESS;
    end else if (release_hit) begin
      dec_o.emit = 1'b1;
      dec_o.kind = KIND_PRINT_RELEASE;
    end else if (pause_hit) begin
      dec_o.emit = 1'b1;
      dec_o.kind = KIND_PAUSE;
    end else begin
      dec_o.emit = 1'b0;
    end
    if (dec_o.ack) dec_o.emit = 1'b0;
  end

  always_comb begin
    if (dec_o.emit || pos_i == PosW'(SEQUENCE_DEPTH - 1)) begin
      next_pos_o = '0;
    end else begin
      next_pos_o = pos_i + PosW'(1);
    end
  end

endmodule

>>> tb/keyboard_scancode_assembler_core_tb.sv
`timescale 1ns / 100ps

module keyboard_scancode_assembler_core_tb;
  import ksa_pkg::*;

  localparam int SEQ_DEPTH    = 6;
  localparam int RANDOM_ITEMS = 1750;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int REPORT_LIMIT = 10;

  localparam logic [0:5][7:0] PRESS_SEQ   = {8'hE0, 8'h2A, 8'hE0, 8'h37, 8'h00, 8'h00};
  localparam logic [0:5][7:0] RELEASE_SEQ = {8'hE0, 8'hB7, 8'hE0, 8'hAA, 8'h00, 8'h00};
  localparam logic [0:5][7:0] PAUSE_SEQ   = {8'hE1, 8'h1D, 8'h45, 8'hE1, 8'h9D, 8'hC5};

  typedef struct packed {
    kind_e       kind;
    logic [15:0] code;
  } scan_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  scan_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  code_kind_o;
  logic [15:0] key_code_o;

  logic [7:0]   seq_buf [SEQ_DEPTH];
  logic [2:0]   seq_pos = '0;
  scan_result_t expected_codes [$];
  int           mismatch_count = 0;
  int           accepted_bytes = 0;
  int           hold_request = 0;
  bit           tx_gaps_on = 1'b1;
  bit           rx_gaps_on = 1'b1;

  keyboard_scancode_assembler_core #(
    .SEQUENCE_DEPTH(SEQ_DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .scan_byte_i(scan_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .code_kind_o(code_kind_o),
    .key_code_o (key_code_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic bit seq_matches(input int pos, input logic [0:5][7:0] pat, input int len);
    int i;
    if (pos < len - 1) return 1'b0;
    for (i = 0; i < len; i++) begin
      if (seq_buf[i] != pat[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit finish_code(output scan_result_t res, input kind_e kind,
                                     input logic [15:0] code);
    res.kind = kind;
    res.code = code;
    seq_pos  = '0;
    return 1'b1;
  endfunction

  function automatic bit decode_scan_byte(input logic [7:0] b, output scan_result_t res);
    int pos;
    pos      = seq_pos;
    res.kind = KIND_SINGLE;
    res.code = '0;
    if (b == BYTE_ACK) return 1'b0;
    if (pos >= SEQ_DEPTH) pos = 0;
    seq_buf[pos] = b;
    if (pos == 0 && b != BYTE_EXT0 && b != BYTE_EXT1)
      return finish_code(res, KIND_SINGLE, {8'h00, b});
    if (pos == 1 && seq_buf[0] == BYTE_EXT0) begin
      if (b != PRINT_PART_A && b != PRINT_PART_B)
        return finish_code(res, KIND_EXTENDED, EXT_PREFIX | {8'h00, b});
    end else begin
      if (seq_matches(pos, PRESS_SEQ, PRINT_LEN))
        return finish_code(res, KIND_PRINT_PRESS, 16'h0000);
      if (seq_matches(pos, RELEASE_SEQ, PRINT_LEN))
        return finish_code(res, KIND_PRINT_RELEASE, 16'h0000);
      if (seq_matches(pos, PAUSE_SEQ, PAUSE_LEN))
        return finish_code(res, KIND_PAUSE, 16'h0000);
    end
    pos++;
    if (pos >= SEQ_DEPTH) pos = 0;
    seq_pos = pos[2:0];
    return 1'b0;
  endfunction

  task automatic send_scan_byte(input logic [7:0] b);
    int           gap;
    scan_result_t res;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    scan_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    if (decode_scan_byte(b, res)) expected_codes.push_back(res);
    if (b != BYTE_ACK) accepted_bytes++;
  endtask

  task automatic send_pattern(input logic [0:5][7:0] pat, input int len);
    int i;
    for (i = 0; i < len; i++) send_scan_byte(pat[i]);
  endtask

  task automatic realign();
    while (seq_pos != 0) send_scan_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_codes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic test_single_bytes();
    send_scan_byte(8'h00);
    send_scan_byte(8'hFF);
    send_scan_byte(BYTE_ACK);
    send_scan_byte(8'h80);
  endtask

  task automatic test_extended_codes();
    send_scan_byte(BYTE_EXT0);
    send_scan_byte(BYTE_ACK);
    send_scan_byte(8'h00);
    send_scan_byte(BYTE_EXT0);
    send_scan_byte(8'hFF);
  endtask

  task automatic test_print_and_pause();
    send_pattern(PRESS_SEQ, PRINT_LEN);
    send_pattern(RELEASE_SEQ, PRINT_LEN);
    send_pattern(PAUSE_SEQ, PAUSE_LEN);
  endtask

  task automatic test_position_wrap();
    send_pattern({8'hE0, 8'h2A, 8'hE0, 8'h38, 8'h33, 8'h44}, SEQ_DEPTH);
    send_scan_byte(8'h1C);
  endtask

  task automatic test_output_hold_off();
    int i;
    realign();
    tx_gaps_on   = 1'b0;
    hold_request = 200;
    for (i = 0; i < 30; i++) send_scan_byte(8'(8'h02 + i));
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random_sequences();
    int          start;
    int          pick;
    int          cut;
    int          n;
    int          phase;
    logic [7:0]  b;
    logic [0:5][7:0] pat;
    start = accepted_bytes;
    while (accepted_bytes - start < RANDOM_ITEMS) begin
      phase      = (accepted_bytes - start) % 400;
      tx_gaps_on = phase >= 60;
      rx_gaps_on = phase >= 60;
      if ($urandom_range(0, 19) == 0) send_scan_byte(BYTE_ACK);
      pick = $urandom_range(0, 99);
      if (pick < 85) realign();
      if (pick < 30) begin
        do b = 8'($urandom_range(0, 255)); while (b == BYTE_EXT0 || b == BYTE_EXT1);
        send_scan_byte(b);
      end else if (pick < 45) begin
        do b = 8'($urandom_range(0, 255));
        while ((b == PRINT_PART_A || b == PRINT_PART_B) && $urandom_range(0, 3) != 0);
        send_scan_byte(BYTE_EXT0);
        send_scan_byte(b);
      end else if (pick < 55) begin
        send_pattern(PRESS_SEQ, PRINT_LEN);
      end else if (pick < 65) begin
        send_pattern(RELEASE_SEQ, PRINT_LEN);
      end else if (pick < 75) begin
        send_pattern(PAUSE_SEQ, PAUSE_LEN);
      end else if (pick < 85) begin
        case ($urandom_range(0, 2))
          0: begin pat = PRESS_SEQ;   n = PRINT_LEN; end
          1: begin pat = RELEASE_SEQ; n = PRINT_LEN; end
          default: begin pat = PAUSE_SEQ; n = PAUSE_LEN; end
        endcase
        cut = $urandom_range(1, n - 1);
        send_pattern(pat, cut);
        send_scan_byte(8'($urandom_range(0, 255)));
      end else begin
        n = $urandom_range(1, SEQ_DEPTH);
        repeat (n) send_scan_byte(8'($urandom_range(0, 255)));
      end
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  initial begin
    int busy;
    busy        = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        busy         = hold_request;
        hold_request = 0;
      end
      if (busy > 0) begin
        out_stall_i <= 1'b1;
        busy--;
      end else if (rx_gaps_on && $urandom_range(0, 99) < 30) begin
        out_stall_i <= 1'b1;
        busy = pick_gap();
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    scan_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_codes.size() == 0) begin
        if (mismatch_count < REPORT_LIMIT)
          $display("unexpected result: kind %0d code %h", code_kind_o, key_code_o);
        mismatch_count++;
      end else begin
        want = expected_codes.pop_front();
        if (code_kind_o !== want.kind || key_code_o !== want.code) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("result mismatch: expected kind %0d code %h, got kind %0d code %h",
                     want.kind, want.code, code_kind_o, key_code_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout with %0d results outstanding", expected_codes.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    scan_byte_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_single_bytes();
    wait_for_results();
    test_extended_codes();
    wait_for_results();
    test_print_and_pause();
    wait_for_results();
    test_position_wrap();
    wait_for_results();
    test_output_hold_off();
    wait_for_results();
    test_random_sequences();
    wait_for_results();

    if (expected_codes.size() != 0)
      $display("%0d expected results never arrived", expected_codes.size());
    if (mismatch_count == 0 && expected_codes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
